FILE: src/assert_macros.svh
// Assertion macros shared by the RPN evaluator modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME_CYCLE(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT_CYCLE(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/rpn_pkg.sv
// Package with the types, sizes and codes shared by the RPN evaluator modules.
package rpn_pkg;

    // Stack geometry and operand width.
    localparam int STACK_DEPTH = 32;
    localparam int VALUE_WIDTH = 32;

    localparam int ADDR_W = $clog2(STACK_DEPTH);
    localparam int SP_W   = $clog2(STACK_DEPTH + 1);
    localparam int CNT_W  = $clog2(VALUE_WIDTH);

    // Fixed field widths of the ports.
    localparam int MODE_W      = 3;
    localparam int DIGIT_W     = 4;
    localparam int TOP_W       = 32;
    localparam int DEPTH_OUT_W = 6;
    localparam int ERR_W       = 3;

    localparam logic [SP_W-1:0]    SP_ONE    = SP_W'(1);
    localparam logic [SP_W-1:0]    SP_TWO    = SP_W'(2);
    localparam logic [SP_W-1:0]    SP_FULL   = SP_W'(STACK_DEPTH);
    localparam logic [CNT_W-1:0]   DIV_LAST  = CNT_W'(VALUE_WIDTH - 1);
    localparam logic [DIGIT_W-1:0] DIGIT_MAX = DIGIT_W'(9);

    // Token kinds.
    typedef enum logic [MODE_W-1:0] {
        MODE_DIGIT = 3'd0,
        MODE_ADD   = 3'd1,
        MODE_SUB   = 3'd2,
        MODE_MUL   = 3'd3,
        MODE_DIV   = 3'd4
    } t_mode;

    // Sticky error codes.
    typedef enum logic [ERR_W-1:0] {
        ERR_OK     = 3'd0,
        ERR_UNDER  = 3'd1,
        ERR_DIVZ   = 3'd2,
        ERR_OVER   = 3'd3,
        ERR_SINGLE = 3'd4
    } t_err;

    // What a token does to the stack once it has been checked.
    typedef enum logic [2:0] {
        CLS_NOP,
        CLS_ERR,
        CLS_PUSH,
        CLS_ALU,
        CLS_DIV
    } t_tok_class;

    // Controller states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DECODE,
        ST_DIV,
        ST_WB
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic in_ready;
        logic capture;
        logic decode;
        logic div_step;
        logic write_back;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        t_tok_class cls;
        logic       div_last;
        logic       out_busy;
    } t_dp_status;

endpackage

FILE: src/rpn_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module rpn_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: src/rpn_dpath.sv
// Datapath: token registers, stack with top-of-stack register, ALU, divider, result register.
`include "assert_macros.svh"

module rpn_dpath (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  rpn_pkg::t_dp_cmd                  i_cmd,
    output rpn_pkg::t_dp_status               o_status,
    input  logic [rpn_pkg::MODE_W-1:0]        i_mode,
    input  logic [rpn_pkg::DIGIT_W-1:0]       i_digit_value,
    input  logic                              i_last_token,
    input  logic                              i_out_stall,
    output logic                              o_out_valid,
    output logic signed [rpn_pkg::TOP_W-1:0]  o_top_value,
    output logic [rpn_pkg::DEPTH_OUT_W-1:0]   o_stack_depth,
    output logic [rpn_pkg::ERR_W-1:0]         o_error_code,
    output logic                              o_expression_done
);

    // Captured token.
    logic [rpn_pkg::MODE_W-1:0]       r_mode;
    logic [rpn_pkg::DIGIT_W-1:0]      r_digit;
    logic                             r_last;

    // Expression state. The top of stack lives in r_tos, the rest in the RAM.
    logic [rpn_pkg::SP_W-1:0]         r_sp;
    rpn_pkg::t_err                    r_err;
    logic                             r_seen;
    logic [rpn_pkg::VALUE_WIDTH-1:0]  r_tos;

    // Decode results.
    rpn_pkg::t_tok_class              r_cls;
    rpn_pkg::t_err                    r_new_err;
    logic [rpn_pkg::VALUE_WIDTH-1:0]  r_res;

    // Divider registers.
    logic [rpn_pkg::VALUE_WIDTH-1:0]  r_rem;
    logic [rpn_pkg::VALUE_WIDTH-1:0]  r_quo;
    logic [rpn_pkg::VALUE_WIDTH-1:0]  r_dvs;
    logic                             r_qneg;
    logic [rpn_pkg::CNT_W-1:0]        r_cnt;

    // Result register.
    logic                             r_out_valid;
    logic signed [rpn_pkg::TOP_W-1:0] r_out_top;
    logic [rpn_pkg::DEPTH_OUT_W-1:0]  r_out_depth;
    logic [rpn_pkg::ERR_W-1:0]        r_out_err;
    logic                             r_out_done;

    logic [rpn_pkg::VALUE_WIDTH-1:0]  w_op_a;
    logic [rpn_pkg::VALUE_WIDTH-1:0]  w_a_mag;
    logic [rpn_pkg::VALUE_WIDTH-1:0]  w_b_mag;
    logic                             w_a_neg;
    logic                             w_b_neg;
    rpn_pkg::t_tok_class              w_cls;
    rpn_pkg::t_err                    w_new_err;
    logic [rpn_pkg::VALUE_WIDTH-1:0]  w_alu;
    logic [rpn_pkg::VALUE_WIDTH:0]    w_shifted;
    logic [rpn_pkg::VALUE_WIDTH:0]    w_diff;
    logic                             w_qbit;
    logic [rpn_pkg::VALUE_WIDTH-1:0]  w_quotient;
    logic [rpn_pkg::DIGIT_W-1:0]      w_digit_sat;
    logic [rpn_pkg::SP_W-1:0]         w_post_sp;
    logic [rpn_pkg::VALUE_WIDTH-1:0]  w_post_tos;
    rpn_pkg::t_err                    w_post_err;
    logic                             w_push_wr;
    logic                             w_ram_we;

    // Stack below the top entry.
    rpn_ram #(
        .WIDTH (rpn_pkg::VALUE_WIDTH),
        .DEPTH (rpn_pkg::STACK_DEPTH)
    ) u_stack (
        .i_clk     (i_clk),
        .i_wr_en   (w_ram_we),
        .i_wr_addr (rpn_pkg::ADDR_W'(r_sp - rpn_pkg::SP_ONE)),
        .i_wr_data (r_tos),
        .i_rd_addr (rpn_pkg::ADDR_W'(r_sp - rpn_pkg::SP_TWO)),
        .o_rd_data (w_op_a)
    );

    // Capture the token beat.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_mode  <= i_mode;
            r_digit <= i_digit_value;
            r_last  <= i_last_token;
        end
    end

    // Classify the token against the current state. The first error wins.
    always_comb begin
        w_cls     = rpn_pkg::CLS_NOP;
        w_new_err = rpn_pkg::ERR_OK;
        if (r_err != rpn_pkg::ERR_OK) begin
            w_cls = rpn_pkg::CLS_NOP;
        end else if (r_last && !r_seen) begin
            w_cls     = rpn_pkg::CLS_ERR;
            w_new_err = rpn_pkg::ERR_SINGLE;
        end else if (r_mode == rpn_pkg::MODE_DIGIT) begin
            if (r_sp >= rpn_pkg::SP_FULL) begin
                w_cls     = rpn_pkg::CLS_ERR;
                w_new_err = rpn_pkg::ERR_OVER;
            end else begin
                w_cls = rpn_pkg::CLS_PUSH;
            end
        end else if (r_mode <= rpn_pkg::MODE_DIV) begin
            if (r_sp < rpn_pkg::SP_TWO) begin
                w_cls     = rpn_pkg::CLS_ERR;
                w_new_err = rpn_pkg::ERR_UNDER;
            end else if (r_mode == rpn_pkg::MODE_DIV) begin
                if (r_tos == '0) begin
                    w_cls     = rpn_pkg::CLS_ERR;
                    w_new_err = rpn_pkg::ERR_DIVZ;
                end else begin
                    w_cls = rpn_pkg::CLS_DIV;
                end
            end else begin
                w_cls = rpn_pkg::CLS_ALU;
            end
        end
    end

    // Add, subtract and multiply, all wrapping to the operand width.
    always_comb begin
        case (r_mode)
            rpn_pkg::MODE_ADD: w_alu = w_op_a + r_tos;
            rpn_pkg::MODE_SUB: w_alu = w_op_a - r_tos;
            rpn_pkg::MODE_MUL: w_alu = w_op_a * r_tos;
            default:           w_alu = '0;
        endcase
    end

    // Operand magnitudes for the divider.
    assign w_a_neg = w_op_a[rpn_pkg::VALUE_WIDTH-1];
    assign w_b_neg = r_tos[rpn_pkg::VALUE_WIDTH-1];
    assign w_a_mag = w_a_neg ? ('0 - w_op_a) : w_op_a;
    assign w_b_mag = w_b_neg ? ('0 - r_tos) : r_tos;

    // One restoring division step: shift in a dividend bit, try the subtract.
    assign w_shifted  = {r_rem, r_quo[rpn_pkg::VALUE_WIDTH-1]};
    assign w_diff     = w_shifted - {1'b0, r_dvs};
    assign w_qbit     = !w_diff[rpn_pkg::VALUE_WIDTH];
    assign w_quotient = r_qneg ? ('0 - r_quo) : r_quo;

    // Decode registers and the divider.
    always_ff @(posedge i_clk) begin
        if (i_cmd.decode) begin
            r_cls     <= w_cls;
            r_new_err <= w_new_err;
            r_res     <= w_alu;
            r_rem     <= '0;
            r_quo     <= w_a_mag;
            r_dvs     <= w_b_mag;
            r_qneg    <= w_a_neg ^ w_b_neg;
            r_cnt     <= '0;
        end else if (i_cmd.div_step) begin
            r_rem <= w_qbit ? w_diff[rpn_pkg::VALUE_WIDTH-1:0]
                            : w_shifted[rpn_pkg::VALUE_WIDTH-1:0];
            r_quo <= {r_quo[rpn_pkg::VALUE_WIDTH-2:0], w_qbit};
            r_cnt <= r_cnt + rpn_pkg::CNT_W'(1);
        end
    end

    // State after the token has been applied.
    assign w_digit_sat = (r_digit > rpn_pkg::DIGIT_MAX) ? rpn_pkg::DIGIT_MAX : r_digit;

    always_comb begin
        w_post_sp  = r_sp;
        w_post_tos = r_tos;
        w_post_err = r_err;
        w_push_wr  = 1'b0;
        case (r_cls)
            rpn_pkg::CLS_ERR: begin
                w_post_err = r_new_err;
            end
            rpn_pkg::CLS_PUSH: begin
                w_push_wr  = (r_sp != '0);
                w_post_tos = rpn_pkg::VALUE_WIDTH'(w_digit_sat);
                w_post_sp  = r_sp + rpn_pkg::SP_ONE;
            end
            rpn_pkg::CLS_ALU: begin
                w_post_tos = r_res;
                w_post_sp  = r_sp - rpn_pkg::SP_ONE;
            end
            rpn_pkg::CLS_DIV: begin
                w_post_tos = w_quotient;
                w_post_sp  = r_sp - rpn_pkg::SP_ONE;
            end
            default: begin
                w_post_sp = r_sp;
            end
        endcase
    end

    // A push spills the old top into the RAM.
    assign w_ram_we = i_cmd.write_back && w_push_wr;

    // Expression state; a last token clears it after its result is formed.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sp   <= '0;
            r_err  <= rpn_pkg::ERR_OK;
            r_seen <= 1'b0;
        end else if (i_cmd.write_back) begin
            r_seen <= !r_last;
            if (r_last) begin
                r_sp  <= '0;
                r_err <= rpn_pkg::ERR_OK;
            end else begin
                r_sp  <= w_post_sp;
                r_err <= w_post_err;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.write_back) begin
            r_tos <= w_post_tos;
        end
    end

    // Result beat valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.write_back) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result beat payload.
    always_ff @(posedge i_clk) begin
        if (i_cmd.write_back) begin
            r_out_top   <= (w_post_sp != '0) ? rpn_pkg::TOP_W'(signed'(w_post_tos)) : '0;
            r_out_depth <= rpn_pkg::DEPTH_OUT_W'(w_post_sp);
            r_out_err   <= w_post_err;
            r_out_done  <= r_last;
        end
    end

    assign o_status.cls      = w_cls;
    assign o_status.div_last = (r_cnt == rpn_pkg::DIV_LAST);
    assign o_status.out_busy = r_out_valid && i_out_stall;

    assign o_out_valid       = r_out_valid;
    assign o_top_value       = r_out_top;
    assign o_stack_depth     = r_out_depth;
    assign o_error_code      = r_out_err;
    assign o_expression_done = r_out_done;

    `ASSERT_SAME_CYCLE(a_sp_in_range, i_clk, i_rst_n, 1'b1, r_sp <= rpn_pkg::SP_FULL, "stack pointer beyond depth")
    `ASSERT_NEXT_CYCLE(a_last_clears, i_clk, i_rst_n, i_cmd.write_back && r_last, (r_sp == '0) && (r_err == rpn_pkg::ERR_OK) && !r_seen, "last token did not clear state")
    `ASSERT_SAME_CYCLE(a_wb_has_room, i_clk, i_rst_n, i_cmd.write_back, !(r_out_valid && i_out_stall), "result overwrote a stalled beat")

endmodule

FILE: src/rpn_ctrl.sv
// Controller state machine: sequences capture, decode, divide and write-back.
`include "assert_macros.svh"

module rpn_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  rpn_pkg::t_dp_status i_status,
    output rpn_pkg::t_dp_cmd    o_cmd
);

    rpn_pkg::t_state r_state;
    rpn_pkg::t_state n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rpn_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            rpn_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = rpn_pkg::ST_DECODE;
                end
            end
            rpn_pkg::ST_DECODE: begin
                n_state = (i_status.cls == rpn_pkg::CLS_DIV) ? rpn_pkg::ST_DIV
                                                             : rpn_pkg::ST_WB;
            end
            rpn_pkg::ST_DIV: begin
                if (i_status.div_last) begin
                    n_state = rpn_pkg::ST_WB;
                end
            end
            rpn_pkg::ST_WB: begin
                if (!i_status.out_busy) begin
                    n_state = rpn_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = rpn_pkg::ST_IDLE;
            end
        endcase
    end

    // Commands to the datapath.
    always_comb begin
        o_cmd = '0;
        unique case (r_state)
            rpn_pkg::ST_IDLE: begin
                o_cmd.in_ready = 1'b1;
                o_cmd.capture  = i_in_valid;
            end
            rpn_pkg::ST_DECODE: begin
                o_cmd.decode = 1'b1;
            end
            rpn_pkg::ST_DIV: begin
                o_cmd.div_step = 1'b1;
            end
            rpn_pkg::ST_WB: begin
                o_cmd.write_back = !i_status.out_busy;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

    `ASSERT_NEXT_CYCLE(a_decode_exit, i_clk, i_rst_n, r_state == rpn_pkg::ST_DECODE, (r_state == rpn_pkg::ST_DIV) || (r_state == rpn_pkg::ST_WB), "decode did not advance")
    `ASSERT_NEXT_CYCLE(a_div_runs, i_clk, i_rst_n, (r_state == rpn_pkg::ST_DIV) && !i_status.div_last, r_state == rpn_pkg::ST_DIV, "divider left early")
    `ASSERT_NEXT_CYCLE(a_wb_done, i_clk, i_rst_n, (r_state == rpn_pkg::ST_WB) && !i_status.out_busy, r_state == rpn_pkg::ST_IDLE, "write-back did not return to idle")

endmodule

FILE: src/rpn_stack_evaluator.sv
// Top level of the RPN evaluator: controller and datapath with valid/stall channels.
// A token is captured while idle, then decoded, then divided if it is a divide that runs, then written back.
// The result beat is registered at write-back; write-back waits while a stalled result beat is held.
// A new token is taken only after write-back; the radix-2 divider forms one quotient bit per cycle for 32 bits.
// Reset (synchronous, active low) empties the stack and clears the error and result valid.
// Stack memory contents are not cleared; only entries below the stack pointer are read.
module rpn_stack_evaluator (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [rpn_pkg::MODE_W-1:0]        i_mode,
    input  logic [rpn_pkg::DIGIT_W-1:0]       i_digit_value,
    input  logic                              i_last_token,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic signed [rpn_pkg::TOP_W-1:0]  o_top_value,
    output logic [rpn_pkg::DEPTH_OUT_W-1:0]   o_stack_depth,
    output logic [rpn_pkg::ERR_W-1:0]         o_error_code,
    output logic                              o_expression_done
);

    rpn_pkg::t_dp_cmd    w_cmd;
    rpn_pkg::t_dp_status w_status;

    // Sequencer.
    rpn_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    // Stack, arithmetic and result register.
    rpn_dpath u_dpath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (w_cmd),
        .o_status          (w_status),
        .i_mode            (i_mode),
        .i_digit_value     (i_digit_value),
        .i_last_token      (i_last_token),
        .i_out_stall       (i_out_stall),
        .o_out_valid       (o_out_valid),
        .o_top_value       (o_top_value),
        .o_stack_depth     (o_stack_depth),
        .o_error_code      (o_error_code),
        .o_expression_done (o_expression_done)
    );

    // Tokens are taken only while the sequencer is idle.
    assign o_in_stall = !w_cmd.in_ready;

endmodule

FILE: tb/sv/tb_rpn_stack_evaluator.sv
// Self-checking testbench for the RPN stack evaluator: directed token sequences, then random traffic.
`timescale 1ns / 100ps

module tb_rpn_stack_evaluator;

    // One result beat as the evaluator reports it.
    typedef struct packed {
        logic signed [rpn_pkg::TOP_W-1:0] top;
        logic [rpn_pkg::DEPTH_OUT_W-1:0]  depth;
        logic [rpn_pkg::ERR_W-1:0]        err;
        logic                             done;
    } t_eval_result;

    // Clock, reset and the ports of the evaluator.
    logic                             i_clk;
    logic                             i_rst_n       = 1'b0;
    logic                             i_in_valid    = 1'b0;
    logic                             o_in_stall;
    logic [rpn_pkg::MODE_W-1:0]       i_mode        = '0;
    logic [rpn_pkg::DIGIT_W-1:0]      i_digit_value = '0;
    logic                             i_last_token  = 1'b0;
    logic                             o_out_valid;
    logic                             i_out_stall   = 1'b0;
    logic signed [rpn_pkg::TOP_W-1:0] o_top_value;
    logic [rpn_pkg::DEPTH_OUT_W-1:0]  o_stack_depth;
    logic [rpn_pkg::ERR_W-1:0]        o_error_code;
    logic                             o_expression_done;

    // Shadow copy of the evaluator state.
    logic [rpn_pkg::VALUE_WIDTH-1:0]  shadow_stack [rpn_pkg::STACK_DEPTH];
    int                               shadow_sp   = 0;
    rpn_pkg::t_err                    shadow_err  = rpn_pkg::ERR_OK;
    bit                               shadow_seen = 1'b0;

    // Results still owed by the evaluator, oldest first.
    t_eval_result                     pending_results [$];

    // Traffic shaping and bookkeeping.
    int                               send_idle_pct  = 0;
    int                               out_stall_pct  = 0;
    int                               tokens_sent    = 0;
    int                               exprs_sent     = 0;
    int                               results_seen   = 0;
    int                               fail_count     = 0;
    int                               err_hits [5]   = '{default: 0};

    rpn_stack_evaluator dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_mode            (i_mode),
        .i_digit_value     (i_digit_value),
        .i_last_token      (i_last_token),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_top_value       (o_top_value),
        .o_stack_depth     (o_stack_depth),
        .o_error_code      (o_error_code),
        .o_expression_done (o_expression_done)
    );

    // Free-running clock with a 2 ns period.
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Watchdog for a run that hangs.
    initial begin
        #2000000;
        $display("TB_ERROR");
        $finish;
    end

    // Apply one token to the shadow state and return the result it should produce.
    function automatic t_eval_result evaluate_token(input logic [rpn_pkg::MODE_W-1:0] mode,
                                                    input logic [rpn_pkg::DIGIT_W-1:0] digit,
                                                    input logic last);
        logic [rpn_pkg::DIGIT_W-1:0]     d;
        logic [rpn_pkg::VALUE_WIDTH-1:0] a;
        logic [rpn_pkg::VALUE_WIDTH-1:0] b;
        logic [rpn_pkg::VALUE_WIDTH-1:0] r;
        longint                          qa;
        longint                          qb;
        bit                              ok;
        t_eval_result                    res;
        d = (digit > rpn_pkg::DIGIT_MAX) ? rpn_pkg::DIGIT_MAX : digit;
        if (shadow_err == rpn_pkg::ERR_OK) begin
            if (last && !shadow_seen) begin
                // A lone token is rejected before anything else is looked at.
                shadow_err = rpn_pkg::ERR_SINGLE;
            end else if (mode == rpn_pkg::MODE_DIGIT) begin
                if (shadow_sp >= rpn_pkg::STACK_DEPTH) begin
                    shadow_err = rpn_pkg::ERR_OVER;
                end else begin
                    shadow_stack[shadow_sp] = rpn_pkg::VALUE_WIDTH'(d);
                    shadow_sp++;
                end
            end else if (mode <= rpn_pkg::MODE_DIV) begin
                if (shadow_sp < 2) begin
                    shadow_err = rpn_pkg::ERR_UNDER;
                end else begin
                    a  = shadow_stack[shadow_sp - 2];
                    b  = shadow_stack[shadow_sp - 1];
                    r  = '0;
                    ok = 1'b1;
                    case (mode)
                        rpn_pkg::MODE_ADD: r = a + b;
                        rpn_pkg::MODE_SUB: r = a - b;
                        rpn_pkg::MODE_MUL: r = a * b;
                        default: begin
                            if (b == '0) begin
                                shadow_err = rpn_pkg::ERR_DIVZ;
                                ok = 1'b0;
                            end else begin
                                // Divide at 64 bits so the most negative over minus one wraps.
                                qa = longint'($signed(a));
                                qb = longint'($signed(b));
                                r  = rpn_pkg::VALUE_WIDTH'(qa / qb);
                            end
                        end
                    endcase
                    if (ok) begin
                        shadow_sp--;
                        shadow_stack[shadow_sp - 1] = r;
                    end
                end
            end
        end
        shadow_seen = 1'b1;
        res.top   = (shadow_sp != 0) ?
                    rpn_pkg::TOP_W'($signed(shadow_stack[shadow_sp - 1])) : '0;
        res.depth = rpn_pkg::DEPTH_OUT_W'(shadow_sp);
        res.err   = shadow_err;
        res.done  = last;
        if (last) begin
            shadow_sp   = 0;
            shadow_err  = rpn_pkg::ERR_OK;
            shadow_seen = 1'b0;
        end
        return res;
    endfunction

    // Send one token beat after a random idle gap and record its expected result.
    task automatic send_token(input logic [rpn_pkg::MODE_W-1:0] mode,
                              input logic [rpn_pkg::DIGIT_W-1:0] digit,
                              input logic last);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct) gap++;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_mode        <= mode;
        i_digit_value <= digit;
        i_last_token  <= last;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        pending_results.insert(pending_results.size(), evaluate_token(mode, digit, last));
        tokens_sent++;
        if (last) exprs_sent++;
    endtask

    // Random stall on the result channel.
    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < out_stall_pct);
    end

    // Compare each accepted result beat with the oldest expectation.
    always @(posedge i_clk) begin
        t_eval_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                $error("result beat with no token outstanding");
                fail_count++;
            end else begin
                want = pending_results.pop_front();
                if (o_top_value !== want.top) begin
                    $error("top_value: expected %0d, got %0d", want.top, o_top_value);
                    fail_count++;
                end
                if (o_stack_depth !== want.depth) begin
                    $error("stack_depth: expected %0d, got %0d", want.depth, o_stack_depth);
                    fail_count++;
                end
                if (o_error_code !== want.err) begin
                    $error("error_code: expected %0d, got %0d", want.err, o_error_code);
                    fail_count++;
                end
                if (o_expression_done !== want.done) begin
                    $error("expression_done: expected %0d, got %0d", want.done,
                           o_expression_done);
                    fail_count++;
                end
                if (want.err <= rpn_pkg::ERR_SINGLE) err_hits[want.err]++;
            end
        end
    end

    // Each operator on plain operands, including a negative quotient and ignored tokens.
    task automatic test_operators();
        send_token(rpn_pkg::MODE_DIGIT, 4'd7, 1'b0);
        send_token(rpn_pkg::MODE_DIGIT, 4'd3, 1'b0);
        send_token(rpn_pkg::MODE_ADD,   4'd0, 1'b1);
        send_token(rpn_pkg::MODE_DIGIT, 4'd3, 1'b0);
        send_token(rpn_pkg::MODE_DIGIT, 4'd9, 1'b0);
        send_token(rpn_pkg::MODE_SUB,   4'd0, 1'b0);
        send_token(rpn_pkg::MODE_DIGIT, 4'd9, 1'b0);
        send_token(rpn_pkg::MODE_MUL,   4'd0, 1'b0);
        send_token(rpn_pkg::MODE_DIGIT, 4'd4, 1'b0);
        send_token(rpn_pkg::MODE_DIV,   4'd0, 1'b1);
        // A digit above nine saturates, and the unused modes leave the stack alone.
        send_token(rpn_pkg::MODE_DIGIT, 4'd15, 1'b0);
        send_token(3'd5,                4'd0, 1'b0);
        send_token(3'd7,                4'd15, 1'b0);
        send_token(rpn_pkg::MODE_DIGIT, 4'd0, 1'b0);
        send_token(rpn_pkg::MODE_SUB,   4'd0, 1'b1);
    endtask

    // A lone token, digit or operator, is an error of its own.
    task automatic test_single_token();
        send_token(rpn_pkg::MODE_DIGIT, 4'd5, 1'b1);
        send_token(rpn_pkg::MODE_MUL,   4'd0, 1'b1);
    endtask

    // Operators short of operands, on an empty and a one-deep stack; the error sticks.
    task automatic test_underflow();
        send_token(rpn_pkg::MODE_ADD,   4'd0, 1'b0);
        send_token(rpn_pkg::MODE_DIGIT, 4'd5, 1'b1);
        send_token(rpn_pkg::MODE_DIGIT, 4'd5, 1'b0);
        send_token(rpn_pkg::MODE_DIV,   4'd0, 1'b0);
        send_token(rpn_pkg::MODE_DIGIT, 4'd3, 1'b1);
    endtask

    // A zero divisor keeps both operands and blocks the later tokens.
    task automatic test_divide_by_zero();
        send_token(rpn_pkg::MODE_DIGIT, 4'd6, 1'b0);
        send_token(rpn_pkg::MODE_DIGIT, 4'd0, 1'b0);
        send_token(rpn_pkg::MODE_DIV,   4'd0, 1'b0);
        send_token(rpn_pkg::MODE_ADD,   4'd0, 1'b1);
    endtask

    // Fill the stack, then push once more.
    task automatic test_overflow();
        repeat (rpn_pkg::STACK_DEPTH)
            send_token(rpn_pkg::MODE_DIGIT, rpn_pkg::DIGIT_W'($urandom_range(9)), 1'b0);
        send_token(rpn_pkg::MODE_DIGIT, 4'd5, 1'b0);
        send_token(rpn_pkg::MODE_ADD,   4'd0, 1'b1);
    endtask

    // Build the most negative value from 8^10 * 2 and divide it by minus one.
    task automatic test_most_negative_divide();
        send_token(rpn_pkg::MODE_DIGIT, 4'd8, 1'b0);
        repeat (9) begin
            send_token(rpn_pkg::MODE_DIGIT, 4'd8, 1'b0);
            send_token(rpn_pkg::MODE_MUL,   4'd0, 1'b0);
        end
        send_token(rpn_pkg::MODE_DIGIT, 4'd2, 1'b0);
        send_token(rpn_pkg::MODE_MUL,   4'd0, 1'b0);
        send_token(rpn_pkg::MODE_DIGIT, 4'd0, 1'b0);
        send_token(rpn_pkg::MODE_DIGIT, 4'd1, 1'b0);
        send_token(rpn_pkg::MODE_SUB,   4'd0, 1'b0);
        send_token(rpn_pkg::MODE_DIV,   4'd0, 1'b1);
    endtask

    // Random operator code.
    function automatic logic [rpn_pkg::MODE_W-1:0] random_operator();
        return rpn_pkg::MODE_W'($urandom_range(rpn_pkg::MODE_ADD, rpn_pkg::MODE_DIV));
    endfunction

    // A well-formed expression over a given number of random operands.
    task automatic send_well_formed(input int operands);
        int   pushed;
        int   depth;
        logic last;
        logic [rpn_pkg::DIGIT_W-1:0] d;
        pushed = 0;
        depth  = 0;
        while (pushed < operands || depth > 1) begin
            if (pushed < operands && (depth < 2 || $urandom_range(1) == 1)) begin
                d    = ($urandom_range(7) == 0) ? rpn_pkg::DIGIT_W'($urandom_range(15))
                                                : rpn_pkg::DIGIT_W'($urandom_range(9));
                last = (pushed + 1 == operands) && (depth + 1 == 1);
                send_token(rpn_pkg::MODE_DIGIT, d, last);
                pushed++;
                depth++;
            end else begin
                last = (pushed == operands) && (depth - 1 == 1);
                send_token(random_operator(), rpn_pkg::DIGIT_W'($urandom_range(15)), last);
                depth--;
            end
        end
    endtask

    // Random tokens of any mode and digit, the last one closing the expression.
    task automatic send_noise();
        int len;
        len = $urandom_range(1, 8);
        for (int k = 0; k < len; k++) begin
            send_token(rpn_pkg::MODE_W'($urandom_range(7)),
                       rpn_pkg::DIGIT_W'($urandom_range(15)), k == len - 1);
        end
    endtask

    // Mostly well-formed expressions, some deep enough to overflow, some noise.
    task automatic test_random_traffic(input int idle_pct, input int stall_pct, input int count);
        int start;
        int pick;
        send_idle_pct = idle_pct;
        out_stall_pct = stall_pct;
        start = tokens_sent;
        while (tokens_sent - start < count) begin
            pick = $urandom_range(99);
            if (pick < 75)
                send_well_formed($urandom_range(1, 8));
            else if (pick < 80)
                send_well_formed($urandom_range(rpn_pkg::STACK_DEPTH - 2,
                                                rpn_pkg::STACK_DEPTH + 2));
            else
                send_noise();
        end
    endtask

    // Test sequence.
    initial begin
        int wait_cycles;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_operators();
        test_single_token();
        test_underflow();
        test_divide_by_zero();
        test_overflow();
        test_most_negative_divide();

        test_random_traffic(0,  0,  75);
        test_random_traffic(82, 0,  75);
        test_random_traffic(0,  82, 75);
        test_random_traffic(16, 16, 75);

        // Drain the outstanding results, then let the pipeline settle.
        i_in_valid <= 1'b0;
        wait_cycles = 0;
        while (pending_results.size() != 0 && wait_cycles < 100000) begin
            @(posedge i_clk);
            wait_cycles++;
        end
        repeat (50) @(posedge i_clk);
        if (pending_results.size() != 0) begin
            $error("%0d results never arrived", pending_results.size());
            fail_count++;
        end

        $display("Ran %0d tokens in %0d expressions, %0d result beats checked.",
                 tokens_sent, exprs_sent, results_seen);
        $display("Results by code: ok %0d, underflow %0d, div-by-zero %0d, %s",
                 err_hits[0], err_hits[1], err_hits[2],
                 $sformatf("overflow %0d, single %0d.", err_hits[3], err_hits[4]));
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

FILE: files.f
+incdir+src
src/rpn_pkg.sv
src/rpn_ram.sv
src/rpn_dpath.sv
src/rpn_ctrl.sv
src/rpn_stack_evaluator.sv
tb/sv/tb_rpn_stack_evaluator.sv
